>>> sv/bship_pkg.sv
// Shared types, constants and a helper function for the Burning Ship escape-time unit.
package bship_pkg;

    localparam int FRACTION_BITS = 28;
    localparam int COORD_W       = 32;
    localparam int PIX_W         = 10;
    localparam int STEP_W        = 31;
    localparam int ITER_W        = 12;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_REAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IMAG = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 2'd3;

    localparam logic [STEP_W-1:0]         RST_STEP_SIZE   = 31'd2684355;
    localparam logic signed [COORD_W-1:0] RST_ORIGIN_REAL = -32'sd536870912;
    localparam logic signed [COORD_W-1:0] RST_ORIGIN_IMAG = -32'sd536870912;
    localparam logic [ITER_W-1:0]         RST_MAX_ITER    = 12'd50;

    // pixel times step, and origin plus that product
    localparam int PROD_W = PIX_W + STEP_W;
    localparam int CSUM_W = PROD_W + 2;

    // squares after the fraction shift, and the doubled cross term
    localparam int SQ_W  = 2 * COORD_W - FRACTION_BITS;
    localparam int CR_W  = SQ_W + 1;
    localparam int NXT_W = ((CR_W > COORD_W) ? CR_W : COORD_W) + 2;

    localparam int SAT_W = (NXT_W > CSUM_W) ? NXT_W : CSUM_W;

    localparam logic [2*COORD_W-1:0] ESC_LIMIT = 64'd4 << FRACTION_BITS;

    typedef struct packed {
        logic signed [COORD_W-1:0] c_re;
        logic signed [COORD_W-1:0] c_im;
        logic [PIX_W-1:0]          col;
        logic [PIX_W-1:0]          row;
    } bship_item_t;

    typedef struct packed {
        logic [STEP_W-1:0]         step_size;
        logic signed [COORD_W-1:0] origin_real;
        logic signed [COORD_W-1:0] origin_imag;
        logic [ITER_W-1:0]         iter_cap;
    } bship_cfg_t;

    // clamp to the signed coordinate range
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(64'sd2147483647);
        lo = SAT_W'(-64'sd2147483648);
        if (v > hi) begin
            return 32'sh7FFFFFFF;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return COORD_W'(v);
    endfunction

endpackage

>>> sv/burning_ship_escape_time_unit.sv
// Top level of the Burning Ship escape-time unit: config registers, front end, queue, iterator.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata[23:0]: pixel_col, pixel_row
//  m_       out  m_tvalid/m_tready  m_tdata[31:0]: escape_count, out_col, out_row
//  cfg_     in   cfg_wr_en          cfg_index[1:0], cfg_wdata[31:0]
//
// The front end registers the pixel*step products, then adds the origin and clamps combinationally.
// The iterator loads a point, then runs a multiply state and an update state per iteration,
// then a last test and an output state.
// Reset is synchronous; it clears control state and loads the config registers with their reset values.
// There is no clearing pass. A stalled result blocks the iterator only after the next result is finished; the
// two-entry queue keeps the front end accepting meanwhile, until it fills.
module burning_ship_escape_time_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [9:0] pixel_col, [19:10] pixel_row, [23:20] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [11:0] escape_count, [21:12] out_col, [31:22] out_row
    input  logic        cfg_wr_en,
    input  logic [bship_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bship_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    bship_pkg::bship_cfg_t  cfg_reg;
    logic                   push_valid;
    logic                   push_ready;
    bship_pkg::bship_item_t push_item;
    logic                   pop_valid;
    logic                   pop_ready;
    bship_pkg::bship_item_t pop_item;
    logic [bship_pkg::ITER_W-1:0] res_count;
    logic [bship_pkg::PIX_W-1:0]  res_col;
    logic [bship_pkg::PIX_W-1:0]  res_row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_size   <= bship_pkg::RST_STEP_SIZE;
            cfg_reg.origin_real <= bship_pkg::RST_ORIGIN_REAL;
            cfg_reg.origin_imag <= bship_pkg::RST_ORIGIN_IMAG;
            cfg_reg.iter_cap    <= bship_pkg::RST_MAX_ITER;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bship_pkg::REG_STEP_SIZE: begin
                    cfg_reg.step_size <= cfg_wdata[bship_pkg::STEP_W-1:0];
                end
                bship_pkg::REG_ORIGIN_REAL: begin
                    cfg_reg.origin_real <= signed'(cfg_wdata);
                end
                bship_pkg::REG_ORIGIN_IMAG: begin
                    cfg_reg.origin_imag <= signed'(cfg_wdata);
                end
                bship_pkg::REG_MAX_ITER: begin
                    cfg_reg.iter_cap <= cfg_wdata[bship_pkg::ITER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    bship_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_col     (s_tdata[9:0]),
        .in_row     (s_tdata[19:10]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    bship_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    bship_iter u_iter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .iter_cap  (cfg_reg.iter_cap),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_count (res_count),
        .out_col   (res_col),
        .out_row   (res_row)
    );

    assign m_tdata = {res_row, res_col, res_count};

endmodule

>>> sv/bship_front.sv
// Front end: takes pixel transactions and maps them to complex points c.
module bship_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bship_pkg::bship_cfg_t     cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [bship_pkg::PIX_W-1:0] in_col,
    input  logic [bship_pkg::PIX_W-1:0] in_row,
    output logic                      push_valid,
    input  logic                      push_ready,
    output bship_pkg::bship_item_t    push_item
);

    logic                              v1_reg;
    logic [bship_pkg::PIX_W-1:0]       col_reg;
    logic [bship_pkg::PIX_W-1:0]       row_reg;
    logic [bship_pkg::PROD_W-1:0]      pcol_reg;
    logic [bship_pkg::PROD_W-1:0]      prow_reg;
    logic                              advance;
    logic signed [bship_pkg::CSUM_W-1:0] sum_re;
    logic signed [bship_pkg::CSUM_W-1:0] sum_im;

    assign advance  = !v1_reg || push_ready;
    assign in_ready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            col_reg  <= in_col;
            row_reg  <= in_row;
            pcol_reg <= bship_pkg::PROD_W'(in_col) * bship_pkg::PROD_W'(cfg.step_size);
            prow_reg <= bship_pkg::PROD_W'(in_row) * bship_pkg::PROD_W'(cfg.step_size);
        end
    end

    always_comb begin
        sum_re = bship_pkg::CSUM_W'(cfg.origin_real) + signed'(bship_pkg::CSUM_W'(pcol_reg));
        sum_im = bship_pkg::CSUM_W'(cfg.origin_imag) + signed'(bship_pkg::CSUM_W'(prow_reg));
        push_item.c_re = bship_pkg::sat_coord(bship_pkg::SAT_W'(sum_re));
        push_item.c_im = bship_pkg::sat_coord(bship_pkg::SAT_W'(sum_im));
        push_item.col  = col_reg;
        push_item.row  = row_reg;
    end

    assign push_valid = v1_reg;

endmodule

>>> sv/bship_fifo.sv
// Two-entry queue between the front end and the iteration unit.
module bship_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  bship_pkg::bship_item_t push_item,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output bship_pkg::bship_item_t pop_item
);

    bship_pkg::bship_item_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> sv/bship_iter.sv
// Iteration unit: runs the Burning Ship map per point and holds the result register.
module bship_iter (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [bship_pkg::ITER_W-1:0] iter_cap,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  bship_pkg::bship_item_t      pop_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bship_pkg::ITER_W-1:0] out_count,
    output logic [bship_pkg::PIX_W-1:0] out_col,
    output logic [bship_pkg::PIX_W-1:0] out_row
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_ACC  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam int CW = bship_pkg::COORD_W;

    logic [1:0]                        state_reg;
    logic [1:0]                        state_next;
    bship_pkg::bship_item_t            item_reg;
    logic signed [CW-1:0]              re_reg;
    logic signed [CW-1:0]              im_reg;
    logic [bship_pkg::ITER_W-1:0]      count_reg;
    logic [2*CW-1:0]                   p_rr_reg;
    logic [2*CW-1:0]                   p_ii_reg;
    logic [2*CW-1:0]                   p_ri_reg;
    logic                              out_valid_reg;
    logic [bship_pkg::ITER_W-1:0]      out_count_reg;
    logic [bship_pkg::PIX_W-1:0]       out_col_reg;
    logic [bship_pkg::PIX_W-1:0]       out_row_reg;

    logic [CW-1:0]                     mag_re;
    logic [CW-1:0]                     mag_im;
    logic [bship_pkg::SQ_W-1:0]        sq_re;
    logic [bship_pkg::SQ_W-1:0]        sq_im;
    logic [bship_pkg::CR_W-1:0]        cross_term;
    logic [bship_pkg::SQ_W:0]          mag_sum;
    logic                              escaped;
    logic signed [bship_pkg::NXT_W-1:0] nre;
    logic signed [bship_pkg::NXT_W-1:0] nim;
    logic                              out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign pop_ready = (state_reg == ST_IDLE);

    always_comb begin
        mag_re  = re_reg[CW-1] ? CW'(-re_reg) : CW'(re_reg);
        mag_im  = im_reg[CW-1] ? CW'(-im_reg) : CW'(im_reg);
        sq_re   = bship_pkg::SQ_W'(p_rr_reg >> bship_pkg::FRACTION_BITS);
        sq_im   = bship_pkg::SQ_W'(p_ii_reg >> bship_pkg::FRACTION_BITS);
        cross_term = bship_pkg::CR_W'(p_ri_reg >> (bship_pkg::FRACTION_BITS - 1));
        mag_sum = (bship_pkg::SQ_W+1)'(sq_re) + (bship_pkg::SQ_W+1)'(sq_im);
        escaped = ((2*CW)'(mag_sum) >= bship_pkg::ESC_LIMIT);
        nre = signed'(bship_pkg::NXT_W'(sq_re)) - signed'(bship_pkg::NXT_W'(sq_im))
              + bship_pkg::NXT_W'(item_reg.c_re);
        nim = signed'(bship_pkg::NXT_W'(cross_term)) + bship_pkg::NXT_W'(item_reg.c_im);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = (count_reg < iter_cap) ? ST_ACC : ST_FIN;
            end
            ST_ACC: begin
                state_next = escaped ? ST_FIN : ST_MUL;
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    item_reg  <= pop_item;
                    re_reg    <= pop_item.c_re;
                    im_reg    <= pop_item.c_im;
                    count_reg <= '0;
                end
            end
            ST_MUL: begin
                p_rr_reg <= {{CW{1'b0}}, mag_re} * {{CW{1'b0}}, mag_re};
                p_ii_reg <= {{CW{1'b0}}, mag_im} * {{CW{1'b0}}, mag_im};
                p_ri_reg <= {{CW{1'b0}}, mag_re} * {{CW{1'b0}}, mag_im};
            end
            ST_ACC: begin
                if (!escaped) begin
                    re_reg    <= bship_pkg::sat_coord(bship_pkg::SAT_W'(nre));
                    im_reg    <= bship_pkg::sat_coord(bship_pkg::SAT_W'(nim));
                    count_reg <= count_reg + bship_pkg::ITER_W'(1);
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    out_count_reg <= count_reg;
                    out_col_reg   <= item_reg.col;
                    out_row_reg   <= item_reg.row;
                end
            end
            default: begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_count = out_count_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;

endmodule

>>> test/burning_ship_escape_time_unit_tb.sv
// Self-checking testbench for the Burning Ship escape-time unit: directed corners, then random pixels.
module burning_ship_escape_time_unit_tb;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_ITEMS  = 50;
    localparam int MAX_PRINTS    = 40;

    typedef struct {
        logic [bship_pkg::ITER_W-1:0] count;
        logic [bship_pkg::PIX_W-1:0]  col;
        logic [bship_pkg::PIX_W-1:0]  row;
    } pixel_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [9:0] pixel_col, [19:10] pixel_row, [23:20] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;   // [11:0] escape_count, [21:12] out_col, [31:22] out_row
    logic                             cfg_wr_en;
    logic [bship_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bship_pkg::CFG_DATA_W-1:0] cfg_wdata;

    // register image kept by the testbench
    logic [bship_pkg::STEP_W-1:0]         zoom_step  = bship_pkg::RST_STEP_SIZE;
    logic signed [bship_pkg::COORD_W-1:0] view_re    = bship_pkg::RST_ORIGIN_REAL;
    logic signed [bship_pkg::COORD_W-1:0] view_im    = bship_pkg::RST_ORIGIN_IMAG;
    logic [bship_pkg::ITER_W-1:0]         iter_limit = bship_pkg::RST_MAX_ITER;

    pixel_result_t expected_counts[$];

    int unsigned tx_gap_pct    = 0;
    int unsigned rx_stall_pct  = 0;
    int unsigned mismatches    = 0;
    int unsigned pixels_sent   = 0;
    int unsigned results_seen  = 0;
    int unsigned settings_used = 0;
    int unsigned cycle_count   = 0;

    burning_ship_escape_time_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_counts.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic logic signed [bship_pkg::COORD_W-1:0] clamp_coord(input longint v);
        if (v > longint'(32'sh7FFFFFFF)) begin
            return 32'sh7FFFFFFF;
        end else if (v < longint'(32'sh80000000)) begin
            return 32'sh80000000;
        end
        return v[bship_pkg::COORD_W-1:0];
    endfunction

    // iterations of the Burning Ship map before |z|^2 reaches 4, capped at the iteration limit
    function automatic logic [bship_pkg::ITER_W-1:0] count_escape(
        input logic [bship_pkg::PIX_W-1:0] col,
        input logic [bship_pkg::PIX_W-1:0] row
    );
        longint          c_re;
        longint          c_im;
        longint          re;
        longint          im;
        longint unsigned mag_re;
        longint unsigned mag_im;
        longint unsigned sq_re;
        longint unsigned sq_im;
        longint unsigned cross_term;
        int unsigned     n;
        c_re = clamp_coord(longint'(view_re) + longint'(col) * longint'(zoom_step));
        c_im = clamp_coord(longint'(view_im) + longint'(row) * longint'(zoom_step));
        re = c_re;
        im = c_im;
        n = 0;
        while (n < iter_limit) begin
            mag_re = (re < 0) ? -re : re;
            mag_im = (im < 0) ? -im : im;
            sq_re = (mag_re * mag_re) >> bship_pkg::FRACTION_BITS;
            sq_im = (mag_im * mag_im) >> bship_pkg::FRACTION_BITS;
            cross_term = (mag_re * mag_im) >> (bship_pkg::FRACTION_BITS - 1);
            if (sq_re + sq_im >= (64'd4 << bship_pkg::FRACTION_BITS)) break;
            re = clamp_coord(longint'(sq_re) - longint'(sq_im) + c_re);
            im = clamp_coord(longint'(cross_term) + c_im);
            n++;
        end
        return n[bship_pkg::ITER_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        if (mismatches < MAX_PRINTS) begin
            $display("MISMATCH cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
        end
        mismatches++;
    endtask

    always @(posedge aclk) begin : result_check
        pixel_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_counts.size() == 0) begin
                report_mismatch("unrequested result, tdata", 0, m_tdata);
            end else begin
                want = expected_counts.pop_front();
                results_seen++;
                if (m_tdata[11:0] !== want.count) begin
                    report_mismatch($sformatf("escape_count (%0d,%0d)", want.col, want.row),
                                    want.count, m_tdata[11:0]);
                end
                if (m_tdata[21:12] !== want.col) begin
                    report_mismatch("out_col", want.col, m_tdata[21:12]);
                end
                if (m_tdata[31:22] !== want.row) begin
                    report_mismatch("out_row", want.row, m_tdata[31:22]);
                end
            end
        end
    end

    // leaves tvalid high after the transaction so back-to-back pixels need no toggle
    task automatic send_pixel(input logic [bship_pkg::PIX_W-1:0] col,
                              input logic [bship_pkg::PIX_W-1:0] row);
        pixel_result_t r;
        @(negedge aclk);
        while ($urandom_range(99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, row, col};
        do @(posedge aclk); while (!s_tready);
        r.count = count_escape(col, row);
        r.col   = col;
        r.row   = row;
        expected_counts.push_back(r);
        pixels_sent++;
    endtask

    task automatic end_burst();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (expected_counts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [bship_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bship_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            bship_pkg::REG_STEP_SIZE:   zoom_step  = data[bship_pkg::STEP_W-1:0];
            bship_pkg::REG_ORIGIN_REAL: view_re    = data;
            bship_pkg::REG_ORIGIN_IMAG: view_im    = data;
            bship_pkg::REG_MAX_ITER:    iter_limit = data[bship_pkg::ITER_W-1:0];
            default: ;
        endcase
    endtask

    // upper bits beyond each register width may carry junk; the block must drop them
    task automatic apply_settings(input logic [31:0] step_word, input logic [31:0] re_word,
                                  input logic [31:0] im_word, input logic [31:0] iter_word);
        write_reg(bship_pkg::REG_STEP_SIZE, step_word);
        write_reg(bship_pkg::REG_ORIGIN_REAL, re_word);
        write_reg(bship_pkg::REG_ORIGIN_IMAG, im_word);
        write_reg(bship_pkg::REG_MAX_ITER, iter_word);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic test_reset_values();
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'h2AA, 10'h155);
        send_pixel(10'h155, 10'h2AA);
        send_pixel(10'd200, 10'd200);   // c near zero, never escapes
        end_burst();
        wait_idle();
    endtask

    task automatic test_iteration_limits();
        apply_settings(32'd2684355, 32'hE000_0000, 32'hE000_0000, 32'hFFFF_F000);
        send_pixel(10'd200, 10'd200);
        send_pixel(10'd5, 10'd900);
        end_burst();
        wait_idle();
        apply_settings(32'd2684355, 32'hE000_0000, 32'hE000_0000, 32'd1);
        send_pixel(10'd200, 10'd200);
        send_pixel(10'd1023, 10'd7);
        end_burst();
        wait_idle();
        // origin at zero with the finest step: the full 4095 iterations run
        apply_settings(32'd1, 32'd0, 32'd0, 32'd4095);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd3, 10'd5);
        end_burst();
        wait_idle();
    endtask

    task automatic test_coordinate_saturation();
        apply_settings(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd50);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1, 10'd1);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd0, 10'd1023);
        end_burst();
        wait_idle();
        apply_settings(32'd1, 32'h8000_0000, 32'h8000_0000, 32'd50);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        end_burst();
        wait_idle();
    endtask

    // mostly viewports over the interesting part of the plane, some raw noise settings
    task automatic test_random_pixels(input int unsigned num_settings);
        logic [31:0] step_word;
        logic [31:0] re_word;
        logic [31:0] im_word;
        logic [31:0] iter_word;
        for (int s = 0; s < num_settings; s++) begin
            if ($urandom_range(3) == 0) begin
                step_word = $urandom;
                re_word   = $urandom;
                im_word   = $urandom;
                iter_word = ($urandom & 32'hFFFF_F000) | $urandom_range(1, 200);
            end else begin
                step_word = $urandom_range(1 << 18, 3 << 19) | ($urandom & 32'h8000_0000);
                re_word   = -$urandom_range(1 << 28, 5 << 27);
                im_word   = -$urandom_range(1 << 27, 9 << 26);
                iter_word = ($urandom_range(7) == 0) ? $urandom_range(121, 400)
                                                     : $urandom_range(1, 120);
            end
            apply_settings(step_word, re_word, im_word, iter_word);
            for (int i = 0; i < RANDOM_ITEMS; i++) begin
                send_pixel($urandom_range(1023), $urandom_range(1023));
            end
            end_burst();
            wait_idle();
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        tx_gap_pct   = 28;
        rx_stall_pct = 78;
        test_reset_values();
        test_iteration_limits();
        test_coordinate_saturation();
        test_random_pixels(4);

        tx_gap_pct   = 78;
        rx_stall_pct = 28;
        test_random_pixels(4);

        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        test_random_pixels(4);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_counts.size() != 0) begin
            report_mismatch("results never returned", expected_counts.size(), 0);
        end
        $display("Ran %0d pixels over %0d register settings, %0d results compared, %0d mismatches",
                 pixels_sent, settings_used, results_seen, mismatches);
        $display("Covered iteration limits 0, 1 and 4095, clamped coordinates, three stall mixes");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
